>>> hdl/bee_pkg.sv
// Package for the byte entropy estimator: widths, constants, controller
// states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
package bee_pkg;

  // window and histogram sizing
  localparam int MaxWindow = 16384;
  localparam int Bins      = 256;
  localparam int BinAddrW  = $clog2(Bins);
  localparam int CntW      = 15;

  // fixed-point log2
  localparam int FracBits   = 16;
  localparam int GuardBits  = 8;
  localparam int FracIters  = FracBits + GuardBits;
  localparam int KW         = $clog2(CntW);
  localparam int LogRawW    = KW + FracIters;
  localparam int LogW       = KW + FracBits;
  localparam int LogItW     = $clog2(FracIters);
  localparam int MantW      = 32;

  // products, sums and the divider
  localparam int ProdW  = CntW + LogW;
  localparam int AccW   = ProdW + 2;
  localparam int DivW   = ProdW;
  localparam int DivItW = $clog2(DivW);

  // result fields
  localparam int ByteW = 8;
  localparam int EntW  = 20;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INC,
    S_LN_START,
    S_LN_WAIT,
    S_B_RD,
    S_B_CHK,
    S_B_LOG,
    S_B_ACC,
    S_DIV_START,
    S_DIV_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic                ram_en;
    logic                ram_we;
    logic                ram_wzero;
    logic                addr_byte_in;
    logic                addr_byte_q;
    logic [BinAddrW-1:0] bin_addr;
    logic                byte_load;
    logic                cnt_inc;
    logic                ovf_set;
    logic                log_start;
    logic                log_sel_n;
    logic                tot_load;
    logic                acc_clear;
    logic                prod_load;
    logic                acc_add;
    logic                div_start;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic count_full;
    logic rdata_zero;
    logic log_done;
    logic div_done;
  } sts_t;

endpackage

>>> hdl/bee_if.sv
// Channel interfaces for the byte entropy estimator: byte words in, results out.
// Depends on bee_pkg.
`timescale 1ns / 1ps
interface bee_byte_if;
  logic                       valid;
  logic                       ready;
  logic [bee_pkg::ByteW-1:0]  byte_value;
  logic                       last;

  modport source (output valid, output byte_value, output last, input ready);
  modport sink   (input valid, input byte_value, input last, output ready);
endinterface

interface bee_result_if;
  logic                      valid;
  logic                      ready;
  logic [bee_pkg::EntW-1:0]  entropy_bits;
  logic [bee_pkg::CntW-1:0]  window_length;
  logic                      window_overflow;

  modport source (output valid, output entropy_bits, output window_length,
                  output window_overflow, input ready);
  modport sink   (input valid, input entropy_bits, input window_length,
                  input window_overflow, output ready);
endinterface

>>> hdl/bee_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> hdl/bee_log2.sv
// Iterative fixed-point log2: one fraction bit per cycle by repeated squaring.
// Depends on bee_pkg.
`timescale 1ns / 1ps
module bee_log2 (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bee_pkg::CntW-1:0] x_i,
  output logic                     done_o,
  output logic [bee_pkg::LogW-1:0] log_o
);
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [bee_pkg::LogItW-1:0]    it_q, it_d;
  logic [bee_pkg::KW-1:0]        k_q, k_d, k_in;
  logic [bee_pkg::MantW-1:0]     m_q, m_d, m_init;
  logic [bee_pkg::FracIters-1:0] f_q, f_d;
  logic [2*bee_pkg::MantW-1:0]   sq;
  logic [bee_pkg::MantW:0]       m_next;
  logic [bee_pkg::LogRawW-1:0]   raw_sum;

  // top set bit and normalized mantissa
  always_comb begin
    k_in = '0;
    for (int i = 0; i < bee_pkg::CntW; i++) begin
      if (x_i[i]) begin
        k_in = bee_pkg::KW'(i);
      end
    end
    m_init = bee_pkg::MantW'(x_i) << (bee_pkg::MantW'(bee_pkg::MantW - 1) - bee_pkg::MantW'(k_in));
  end

  // one squaring step
  always_comb begin
    sq     = (2*bee_pkg::MantW)'(m_q) * (2*bee_pkg::MantW)'(m_q);
    m_next = sq[2*bee_pkg::MantW-1:bee_pkg::MantW-1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    it_d   = it_q;
    k_d    = k_q;
    m_d    = m_q;
    f_d    = f_q;
    if (start_i) begin
      busy_d = 1'b1;
      it_d   = '0;
      k_d    = k_in;
      m_d    = m_init;
      f_d    = '0;
    end else if (busy_q) begin
      if (m_next[bee_pkg::MantW]) begin
        m_d = m_next[bee_pkg::MantW:1];
        f_d = {f_q[bee_pkg::FracIters-2:0], 1'b1};
      end else begin
        m_d = m_next[bee_pkg::MantW-1:0];
        f_d = {f_q[bee_pkg::FracIters-2:0], 1'b0};
      end
      it_d = it_q + 1'b1;
      if (it_q == bee_pkg::LogItW'(bee_pkg::FracIters - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    m_q <= m_d;
    f_q <= f_d;
  end

  // round off the guard bits
  assign raw_sum = {k_q, f_q} + bee_pkg::LogRawW'(1 << (bee_pkg::GuardBits - 1));
  assign log_o   = raw_sum[bee_pkg::LogRawW-1:bee_pkg::GuardBits];
  assign done_o  = done_q;
endmodule

>>> hdl/bee_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bee_pkg.
`timescale 1ns / 1ps
module bee_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bee_pkg::DivW-1:0] dividend_i,
  input  logic [bee_pkg::CntW-1:0] divisor_i,
  output logic                     done_o,
  output logic [bee_pkg::DivW-1:0] quot_o
);
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [bee_pkg::DivItW-1:0]   it_q, it_d;
  logic [bee_pkg::CntW-1:0]     rem_q, rem_d, dsr_q, dsr_d;
  logic [bee_pkg::DivW-1:0]     q_q, q_d;
  logic [bee_pkg::CntW:0]       r2, diff;
  logic                         ge;

  // trial subtract
  always_comb begin
    r2   = {rem_q, q_q[bee_pkg::DivW-1]};
    diff = r2 - {1'b0, dsr_q};
    ge   = (r2 >= {1'b0, dsr_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    it_d   = it_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    q_d    = q_q;
    if (start_i) begin
      busy_d = 1'b1;
      it_d   = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      q_d    = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[bee_pkg::CntW-1:0] : r2[bee_pkg::CntW-1:0];
      q_d   = {q_q[bee_pkg::DivW-2:0], ge};
      it_d  = it_q + 1'b1;
      if (it_q == bee_pkg::DivItW'(bee_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    q_q   <= q_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

>>> hdl/bee_datapath.sv
// Datapath: histogram RAM, byte count, log2 unit, sum of c*log2(c), divider
// and the result register. Depends on bee_pkg, bee_ram, bee_log2, bee_div.
`timescale 1ns / 1ps
module bee_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bee_pkg::cmd_t             cmd_i,
  output bee_pkg::sts_t             sts_o,
  input  logic [bee_pkg::ByteW-1:0] byte_value_i,
  output logic [bee_pkg::EntW-1:0]  entropy_bits_o,
  output logic [bee_pkg::CntW-1:0]  window_length_o,
  output logic                      window_overflow_o
);
  logic [bee_pkg::CntW-1:0]     count_q, count_d;
  logic                         ovf_q, ovf_d;
  logic [bee_pkg::ByteW-1:0]    byte_q;
  logic [bee_pkg::ProdW-1:0]    total_q, prod_q;
  logic [bee_pkg::AccW-1:0]     acc_q;
  logic [bee_pkg::EntW-1:0]     ent_q;
  logic [bee_pkg::CntW-1:0]     len_q;
  logic                         ovf_out_q;
  logic [bee_pkg::BinAddrW-1:0] ram_addr;
  logic [bee_pkg::CntW-1:0]     ram_wdata, ram_rdata;
  logic [bee_pkg::CntW-1:0]     log_x;
  logic                         log_done;
  logic [bee_pkg::LogW-1:0]     log_val;
  logic [bee_pkg::ProdW-1:0]    prod_in;
  logic [bee_pkg::AccW-1:0]     total_ext;
  logic [bee_pkg::DivW-1:0]     dividend;
  logic                         div_done;
  logic [bee_pkg::DivW-1:0]     quot;
  logic [bee_pkg::EntW-1:0]     ent_sat;

  // histogram memory
  always_comb begin
    priority if (cmd_i.addr_byte_in) begin
      ram_addr = byte_value_i;
    end else if (cmd_i.addr_byte_q) begin
      ram_addr = byte_q;
    end else begin
      ram_addr = cmd_i.bin_addr;
    end
    ram_wdata = cmd_i.ram_wzero ? '0 : ram_rdata + 1'b1;
  end

  bee_ram #(
    .WIDTH (bee_pkg::CntW),
    .DEPTH (bee_pkg::Bins)
  ) u_hist (
    .clk_i   (clk_i),
    .en_i    (cmd_i.ram_en),
    .we_i    (cmd_i.ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // byte count and overflow flag, cleared when the result is loaded for output
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.out_load) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_d = count_q + 1'b1;
      end
      if (cmd_i.ovf_set) begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // log2 of the count or of one bin
  assign log_x = cmd_i.log_sel_n ? count_q : ram_rdata;

  bee_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .log_o   (log_val)
  );

  assign prod_in = bee_pkg::ProdW'(log_x) * bee_pkg::ProdW'(log_val);

  // products and running sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_load) begin
      byte_q <= byte_value_i;
    end
    if (cmd_i.tot_load) begin
      total_q <= prod_in;
    end
    if (cmd_i.prod_load) begin
      prod_q <= prod_in;
    end
    if (cmd_i.acc_clear) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + bee_pkg::AccW'(prod_q);
    end
  end

  // n*log2(n) minus the sum, floored at zero, divided by n
  always_comb begin
    total_ext = bee_pkg::AccW'(total_q);
    if (total_ext >= acc_q) begin
      dividend = bee_pkg::DivW'(total_ext - acc_q);
    end else begin
      dividend = '0;
    end
  end

  bee_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // result register
  assign ent_sat = (|quot[bee_pkg::DivW-1:bee_pkg::EntW]) ? '1 : quot[bee_pkg::EntW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ent_q     <= ent_sat;
      len_q     <= count_q;
      ovf_out_q <= ovf_q;
    end
  end

  assign entropy_bits_o    = ent_q;
  assign window_length_o   = len_q;
  assign window_overflow_o = ovf_out_q;

  // status to the controller
  assign sts_o.count_full = (count_q == bee_pkg::CntW'(bee_pkg::MaxWindow));
  assign sts_o.rdata_zero = (ram_rdata == '0);
  assign sts_o.log_done   = log_done;
  assign sts_o.div_done   = div_done;
endmodule

>>> hdl/bee_ctrl.sv
// Controller: sequences counting, the end-of-window bin walk, the divide
// and the output handshake. Depends on bee_pkg.
`timescale 1ns / 1ps
module bee_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  bee_pkg::sts_t    sts_i,
  output bee_pkg::cmd_t    cmd_o
);
  bee_pkg::state_e               state_q, state_d;
  logic [bee_pkg::BinAddrW-1:0]  bin_q, bin_d;
  logic                          last_q, last_d;
  logic                          out_valid_q, out_valid_d;
  logic                          accept;
  logic                          bin_end;
  logic                          out_free;

  assign accept   = (state_q == bee_pkg::S_IDLE) && in_valid_i;
  assign bin_end  = (bin_q == '1);
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    last_d  = last_q;
    unique case (state_q)
      bee_pkg::S_CLEAR: begin
        bin_d = bin_q + 1'b1;
        if (bin_end) begin
          state_d = bee_pkg::S_IDLE;
        end
      end
      bee_pkg::S_IDLE: begin
        if (accept) begin
          last_d = in_last_i;
          if (!sts_i.count_full) begin
            state_d = bee_pkg::S_INC;
          end else if (in_last_i) begin
            state_d = bee_pkg::S_LN_START;
          end
        end
      end
      bee_pkg::S_INC: begin
        state_d = last_q ? bee_pkg::S_LN_START : bee_pkg::S_IDLE;
      end
      bee_pkg::S_LN_START: state_d = bee_pkg::S_LN_WAIT;
      bee_pkg::S_LN_WAIT: begin
        if (sts_i.log_done) begin
          bin_d   = '0;
          state_d = bee_pkg::S_B_RD;
        end
      end
      bee_pkg::S_B_RD: state_d = bee_pkg::S_B_CHK;
      bee_pkg::S_B_CHK: begin
        if (!sts_i.rdata_zero) begin
          state_d = bee_pkg::S_B_LOG;
        end else begin
          bin_d   = bin_q + 1'b1;
          state_d = bin_end ? bee_pkg::S_DIV_START : bee_pkg::S_B_RD;
        end
      end
      bee_pkg::S_B_LOG: begin
        if (sts_i.log_done) begin
          state_d = bee_pkg::S_B_ACC;
        end
      end
      bee_pkg::S_B_ACC: begin
        bin_d   = bin_q + 1'b1;
        state_d = bin_end ? bee_pkg::S_DIV_START : bee_pkg::S_B_RD;
      end
      bee_pkg::S_DIV_START: state_d = bee_pkg::S_DIV_WAIT;
      bee_pkg::S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = bee_pkg::S_OUT;
        end
      end
      bee_pkg::S_OUT: begin
        if (out_free) begin
          state_d = bee_pkg::S_IDLE;
        end
      end
      default: state_d = bee_pkg::S_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.bin_addr = bin_q;
    unique case (state_q)
      bee_pkg::S_CLEAR: begin
        cmd_o.ram_en    = 1'b1;
        cmd_o.ram_we    = 1'b1;
        cmd_o.ram_wzero = 1'b1;
      end
      bee_pkg::S_IDLE: begin
        if (accept) begin
          if (sts_i.count_full) begin
            cmd_o.ovf_set = 1'b1;
          end else begin
            cmd_o.ram_en       = 1'b1;
            cmd_o.addr_byte_in = 1'b1;
            cmd_o.byte_load    = 1'b1;
          end
        end
      end
      bee_pkg::S_INC: begin
        cmd_o.ram_en      = 1'b1;
        cmd_o.ram_we      = 1'b1;
        cmd_o.addr_byte_q = 1'b1;
        cmd_o.cnt_inc     = 1'b1;
      end
      bee_pkg::S_LN_START: begin
        cmd_o.log_start = 1'b1;
        cmd_o.log_sel_n = 1'b1;
      end
      bee_pkg::S_LN_WAIT: begin
        cmd_o.log_sel_n = 1'b1;
        if (sts_i.log_done) begin
          cmd_o.tot_load  = 1'b1;
          cmd_o.acc_clear = 1'b1;
        end
      end
      bee_pkg::S_B_RD: begin
        cmd_o.ram_en = 1'b1;
      end
      bee_pkg::S_B_CHK: begin
        // clear the bin while its count sits in the read register
        cmd_o.ram_en    = 1'b1;
        cmd_o.ram_we    = 1'b1;
        cmd_o.ram_wzero = 1'b1;
        cmd_o.log_start = !sts_i.rdata_zero;
      end
      bee_pkg::S_B_LOG: begin
        cmd_o.prod_load = sts_i.log_done;
      end
      bee_pkg::S_B_ACC: begin
        cmd_o.acc_add = 1'b1;
      end
      bee_pkg::S_DIV_START: begin
        cmd_o.div_start = 1'b1;
      end
      bee_pkg::S_DIV_WAIT: begin
        cmd_o.ram_en = 1'b0;
      end
      bee_pkg::S_OUT: begin
        cmd_o.out_load = out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bee_pkg::S_CLEAR;
      bin_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bin_q       <= bin_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == bee_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
endmodule

>>> hdl/byte_entropy_estimator_core.sv
// Byte entropy estimator: counts a window of bytes into a 256-bin histogram
// and reports its Shannon entropy. Usage notes:
//   - byte_i carries one byte word per transfer (valid/ready) with a last
//     flag closing the window; result_o carries one result word per window:
//     entropy in bits per byte with 16 fraction bits, window length and an
//     overflow flag set when bytes arrived after 16384 were counted.
//   - each byte is counted by a read then a write of its histogram bin, and
//     no new byte is taken until the write; a byte past the full window is
//     only flagged as overflow.
//   - after a last byte the block takes log2 of the window length, walks all
//     256 bins taking log2 of each non-empty bin (one bit per squaring) and
//     then runs the bit-serial divide. Bins are cleared during the same walk.
//   - after reset the histogram RAM is cleared bin by bin, during which no
//     byte is taken.
//   - the result sits in an output register; while the receiver stalls,
//     the next window is still taken and counted, and only its own result
//     waits for the register to free up.
// Depends on bee_pkg, bee_if, bee_ctrl, bee_datapath.
`timescale 1ns / 1ps
module byte_entropy_estimator_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  bee_byte_if.sink            byte_i,
  bee_result_if.source        result_o
);
  bee_pkg::cmd_t cmd;
  bee_pkg::sts_t sts;

  // sequencer
  bee_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_i.valid),
    .in_last_i   (byte_i.last),
    .in_ready_o  (byte_i.ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and storage
  bee_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .byte_value_i      (byte_i.byte_value),
    .entropy_bits_o    (result_o.entropy_bits),
    .window_length_o   (result_o.window_length),
    .window_overflow_o (result_o.window_overflow)
  );
endmodule

>>> sim/testbench.sv
// Self-checking testbench for byte_entropy_estimator_core: random byte windows
// go in, entropy results are predicted in the bench and compared field by field.
// Depends on bee_pkg, bee_if and the core RTL.
`timescale 1ns / 1ps
module testbench;
  import bee_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic             last;
  } byte_word_t;

  typedef struct packed {
    logic [EntW-1:0] entropy_bits;
    logic [CntW-1:0] window_length;
    logic            window_overflow;
  } result_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bee_byte_if   byte_ch ();
  bee_result_if res_ch ();

  byte_entropy_estimator_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_ch.sink),
    .result_o (res_ch.source)
  );

  always #4 clk_i = ~clk_i;

  // predictor state: histogram, count and overflow flag
  int unsigned  hist_bins [Bins];
  int unsigned  win_count;
  bit           win_ovf;
  result_word_t expected_results [$];
  byte_word_t   pending_bytes [$];
  int unsigned  error_count = 0;
  longint unsigned cycle_count = 0;
  bit           hold_sender = 1'b0;
  bit           stim_done = 1'b0;

  // fixed-point log2 with guard bits, rounded to FracBits
  function automatic longint unsigned log2_fixed(int unsigned x);
    int unsigned     k;
    longint unsigned m;
    longint unsigned f;
    k = 0;
    f = 0;
    if (x == 0) return 0;
    while ((x >> k) > 1) k++;
    m = longint'(x) << (31 - k);
    for (int i = 0; i < FracIters; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    f = f | (longint'(k) << FracIters);
    return (f + (64'd1 << (GuardBits - 1))) >> GuardBits;
  endfunction

  // count one accepted byte word, predict a result on last
  task automatic count_byte(byte_word_t w);
    longint unsigned total;
    longint unsigned bin_sum;
    longint unsigned ent;
    result_word_t    r;
    if (win_count < MaxWindow) begin
      hist_bins[w.byte_value]++;
      win_count++;
    end else begin
      win_ovf = 1'b1;
    end
    if (w.last) begin
      ent = 0;
      if (win_count != 0) begin
        total = longint'(win_count) * log2_fixed(win_count);
        bin_sum = 0;
        for (int i = 0; i < Bins; i++)
          if (hist_bins[i] != 0)
            bin_sum += longint'(hist_bins[i]) * log2_fixed(hist_bins[i]);
        if (bin_sum <= total) ent = (total - bin_sum) / win_count;
      end
      if (ent > 64'hFFFFF) ent = 64'hFFFFF;
      r.entropy_bits    = ent[EntW-1:0];
      r.window_length   = win_count[CntW-1:0];
      r.window_overflow = win_ovf;
      expected_results.push_back(r);
      foreach (hist_bins[i]) hist_bins[i] = 0;
      win_count = 0;
      win_ovf = 1'b0;
    end
  endtask

  // queue one window of bytes drawn from a small or full alphabet
  task automatic queue_window(int unsigned len, int unsigned alphabet);
    byte_word_t w;
    int unsigned base;
    base = $urandom_range(0, 255);
    for (int unsigned i = 0; i < len; i++) begin
      w.byte_value = (alphabet >= 256) ? 8'($urandom) : 8'(base + $urandom_range(0, alphabet - 1));
      w.last = (i == len - 1);
      pending_bytes.push_back(w);
    end
  endtask

  // driver: bursts with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ch.valid <= 1'b0;
      byte_ch.byte_value <= '0;
      byte_ch.last <= 1'b0;
    end else begin
      if (!byte_ch.valid || byte_ch.ready) begin
        if (byte_ch.valid && byte_ch.ready)
          count_byte({byte_ch.byte_value, byte_ch.last});
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          byte_ch.valid <= 1'b0;
        end else if (pending_bytes.size() != 0 && !hold_sender) begin
          byte_word_t w;
          w = pending_bytes.pop_front();
          byte_ch.valid <= 1'b1;
          byte_ch.byte_value <= w.byte_value;
          byte_ch.last <= w.last;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  logic [15:0] stall_lfsr;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      stall_lfsr <= 16'hACE1;
    end else begin
      stall_lfsr <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
      res_ch.ready <= (cycle_count[11:9] == 3'd0) ? 1'b1 : (stall_lfsr[2:0] != 3'd0);
      if (res_ch.valid && res_ch.ready) begin
        result_word_t got;
        result_word_t want;
        got = {res_ch.entropy_bits, res_ch.window_length, res_ch.window_overflow};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word ent=%h len=%0d ovf=%0b", $realtime,
                   got.entropy_bits, got.window_length, got.window_overflow);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.entropy_bits !== want.entropy_bits) begin
            $display("%0t: entropy expected %h actual %h", $realtime,
                     want.entropy_bits, got.entropy_bits);
            error_count++;
          end
          if (got.window_length !== want.window_length) begin
            $display("%0t: length expected %0d actual %0d", $realtime,
                     want.window_length, got.window_length);
            error_count++;
          end
          if (got.window_overflow !== want.window_overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $realtime,
                     want.window_overflow, got.window_overflow);
            error_count++;
          end
        end
      end
    end
  end

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd100000000) begin
      $display("** byte_entropy_estimator_core: FAILED **");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned choice;
    byte_word_t  w;
    foreach (hist_bins[i]) hist_bins[i] = 0;
    win_count = 0;
    win_ovf = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single bytes at the extremes, uniform, all 256 values
    w = '{8'h00, 1'b1}; pending_bytes.push_back(w);
    w = '{8'hFF, 1'b1}; pending_bytes.push_back(w);
    w = '{8'h55, 1'b0}; pending_bytes.push_back(w);
    w = '{8'hAA, 1'b1}; pending_bytes.push_back(w);
    queue_window(4, 1);
    queue_window(8, 2);
    for (int i = 0; i < 256; i++) begin
      w = '{8'(i), i == 255}; pending_bytes.push_back(w);
    end

    // full window then overflow bytes, last byte past the limit
    queue_window(MaxWindow, 256);
    void'(pending_bytes.pop_back());
    w = '{8'h3C, 1'b0};
    repeat (3) pending_bytes.push_back(w);
    w = '{8'hC3, 1'b1}; pending_bytes.push_back(w);
    // exactly full, no overflow
    queue_window(MaxWindow, 3);

    // hold the sender until everything has come back
    wait (pending_bytes.size() == 0);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0 && !byte_ch.valid);
    hold_sender = 1'b0;

    // random windows, mostly short
    for (int k = 0; k < 120; k++) begin
      choice = $urandom_range(0, 9);
      if (choice < 7)
        queue_window($urandom_range(1, 16), $urandom_range(1, 256));
      else
        queue_window($urandom_range(17, 40), $urandom_range(1, 256));
    end
    wait (pending_bytes.size() == 0);
    wait (expected_results.size() == 0 && !byte_ch.valid);
    repeat (4000) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0)
      $display("** byte_entropy_estimator_core: PASSED **");
    else
      $display("** byte_entropy_estimator_core: FAILED **");
    $finish;
  end
endmodule
